/* hdl/ffha_pkg.sv */
// Package: shared types and codes for the first-fit heap allocator.
`default_nettype none
package ffha_pkg;
  localparam int unsigned AddrW = 32;
  localparam int unsigned LenW  = 24;
  localparam int unsigned StW   = 2;

  localparam logic [StW-1:0] ST_OK       = 2'd0;
  localparam logic [StW-1:0] ST_FULL     = 2'd1;
  localparam logic [StW-1:0] ST_UNKNOWN  = 2'd2;
  localparam logic [StW-1:0] ST_OVERFLOW = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // One table entry.
  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] length;
    logic             used;
  } seg_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic             ins;     // shift up from index at
    logic             rem;     // shift down above at
    logic             wr;      // write entry at
    logic             wr2;     // write entry at2
    logic [9:0]       at;
    logic [9:0]       at2;
    seg_t             val;
    seg_t             val2;
  } cell_cmd_t;
endpackage
`default_nettype wire

/* hdl/ffha_cell.sv */
// Cell: holds one segment entry and shifts with its neighbors.
`default_nettype none
module ffha_cell
  import ffha_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  wire logic      clk_i,
  input  wire cell_cmd_t cmd_i,
  input  wire seg_t      lower_i,
  input  wire seg_t      upper_i,
  output seg_t           seg_o
);
  seg_t seg_q, seg_d;
  logic [9:0] idx;
  assign idx = 10'(Idx);

  always_comb begin
    seg_d = seg_q;
    if (cmd_i.ins && idx > cmd_i.at) seg_d = lower_i;
    if (cmd_i.rem && idx >= cmd_i.at) seg_d = upper_i;
    if (cmd_i.wr && idx == cmd_i.at) seg_d = cmd_i.val;
    if (cmd_i.wr2 && idx == cmd_i.at2) seg_d = cmd_i.val2;
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
  end
  assign seg_o = seg_q;
endmodule
`default_nettype wire

/* hdl/first_fit_heap_allocator.sv */
// Top level: first-fit heap allocator built on a chain of segment cells.
// The result follows a serial walk over the cell chain, one cell per cycle.
// Items are taken one at a time: the input stalls until the current item is done.
// The result register lets the next item enter while a result waits.
// Reset: rst_ni clears control, segment count and heap top; cell contents are don't-care.
`default_nettype none
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 32,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned PAGE_BYTES   = 4096
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [1:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             req_type_i,
  input  wire logic [LenW-1:0]  req_len_i,
  input  wire logic [AddrW-1:0] free_addr_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [AddrW-1:0]      ret_addr_o,
  output logic [AddrW-1:0]      top_before_o,
  output logic [AddrW-1:0]      top_after_o,
  output logic [StW-1:0]        status_o
);
  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned PgW = $clog2(PAGE_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_APP  = 3'd2;
  localparam logic [2:0] S_FREE = 3'd3;
  localparam logic [2:0] S_DROP = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [AddrW-1:0] heap_start_q, heap_top_q, heap_top_d;
  logic [CW-1:0]    cnt_q, cnt_d, idx_q, idx_d;
  logic             type_q;
  logic [AddrW-1:0] need_q, addr_q, before_q, ret_q, ret_d, drop_q, drop_d;
  logic [StW-1:0]   st_q, st_d;
  logic             ov_q;
  logic [AddrW-1:0] ret_addr_q, top_before_q, top_after_q;
  logic [StW-1:0]   status_q;
  logic             out_valid_q;

  cell_cmd_t cmd;
  seg_t      segs [MAX_SEGMENTS];

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      ffha_cell #(.Idx(g)) u_cell (
        .clk_i  (clk_i),
        .cmd_i  (cmd),
        .lower_i(segs[(g == 0) ? 0 : g-1]),
        .upper_i(segs[(g == MAX_SEGMENTS-1) ? g : g+1]),
        .seg_o  (segs[g])
      );
    end
  endgenerate

  // APB
  assign pready = 1'b1;
  assign prdata = heap_start_q;
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);

  logic in_acc, out_acc;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;

  // current entry and its neighbors
  logic [IW-1:0] ix, ixn, ixp;
  seg_t cur, nxt, prv;
  logic [AddrW-1:0] rest;
  logic [AddrW:0]   base, endx, gap, topx;
  assign ix  = idx_q[IW-1:0];
  assign ixn = (idx_q + 1'b1 < CW'(MAX_SEGMENTS)) ? IW'(idx_q + 1'b1) : ix;
  assign ixp = (idx_q != '0) ? IW'(idx_q - 1'b1) : ix;
  assign cur = segs[ix];
  assign nxt = segs[ixn];
  assign prv = segs[ixp];
  assign rest = cur.length - need_q;

  // append arithmetic, computed combinationally
  seg_t last;
  assign last = segs[(cnt_q != '0) ? IW'(cnt_q - 1'b1) : '0];
  assign base = (cnt_q != '0) ? ({1'b0, last.start} + {1'b0, last.length})
                              : {1'b0, heap_start_q};
  assign endx = base + {1'b0, need_q};
  assign gap  = endx - {1'b0, heap_top_q};
  assign topx = (endx > {1'b0, heap_top_q})
              ? {1'b0, heap_top_q} + (((gap + (AddrW+1)'(PAGE_BYTES - 1)) >> PgW) << PgW)
              : {1'b0, heap_top_q};

  // lower the heap top by whole pages that lie at or above the dropped start
  logic [AddrW-1:0] span, drop_top;
  assign span = heap_top_q - drop_q;
  assign drop_top = (heap_top_q >= drop_q)
                  ? heap_top_q - {span[AddrW-1:PgW], {PgW{1'b0}}}
                  : heap_top_q;

  always_comb begin
    state_d = state_q; heap_top_d = heap_top_q; cnt_d = cnt_q; idx_d = idx_q;
    ret_d = ret_q; st_d = st_q; drop_d = drop_q;
    cmd = '0;
    unique case (state_q)
      S_IDLE: begin
        if (cfg_wr && cnt_q == '0) heap_top_d = pwdata;
        if (in_acc) begin
          state_d = S_SCAN; idx_d = '0; ret_d = '0; st_d = ST_OK;
        end
      end
      S_SCAN: begin
        if (idx_q >= cnt_q) begin
          state_d = (type_q == REQ_ALLOC) ? S_APP : S_DONE;
          if (type_q == REQ_FREE) st_d = ST_UNKNOWN;
        end else if (type_q == REQ_ALLOC) begin
          if (!cur.used && cur.length >= need_q) begin
            cmd.at = 10'(idx_q);
            cmd.wr = 1'b1;
            cmd.val = '{start: cur.start, length: cur.length, used: 1'b1};
            if (rest > AddrW'(HEADER_BYTES) && cnt_q < CW'(MAX_SEGMENTS)) begin
              cmd.ins = 1'b1; cmd.wr2 = 1'b1;
              cmd.at2 = 10'(idx_q + 1'b1);
              cmd.val.length = need_q;
              cmd.val2 = '{start: cur.start + need_q, length: rest, used: 1'b0};
              cnt_d = cnt_q + 1'b1;
            end
            ret_d = cur.start + AddrW'(HEADER_BYTES);
            state_d = S_DONE;
          end else idx_d = idx_q + 1'b1;
        end else begin
          if (cur.start + AddrW'(HEADER_BYTES) == addr_q) begin
            if (!cur.used) begin st_d = ST_UNKNOWN; state_d = S_DONE; end
            else begin
              // clear used and merge upward
              cmd.wr = 1'b1; cmd.at = 10'(idx_q);
              cmd.val = '{start: cur.start, length: cur.length, used: 1'b0};
              if (idx_q + 1'b1 < cnt_q && !nxt.used) begin
                cmd.val.length = cur.length + nxt.length;
                cmd.rem = 1'b1; cmd.at = 10'(idx_q + 1'b1);
                cmd.wr2 = 1'b1; cmd.at2 = 10'(idx_q); cmd.val2 = cmd.val;
                cmd.wr = 1'b0;
                cnt_d = cnt_q - 1'b1;
              end
              state_d = S_FREE;
            end
          end else idx_d = idx_q + 1'b1;
        end
      end
      S_FREE: begin
        // merge downward
        if (idx_q != '0 && !prv.used) begin
          cmd.rem = 1'b1; cmd.at = 10'(idx_q);
          cmd.wr2 = 1'b1; cmd.at2 = 10'(idx_q - 1'b1);
          cmd.val2 = '{start: prv.start, length: prv.length + cur.length, used: 1'b0};
          cnt_d = cnt_q - 1'b1; idx_d = idx_q - 1'b1;
          if (idx_q == cnt_q - 1'b1) begin
            drop_d = prv.start; cnt_d = cnt_q - 2'd2; state_d = S_DROP;
          end else state_d = S_DONE;
        end else if (idx_q + 1'b1 == cnt_q) begin
          drop_d = cur.start; cnt_d = cnt_q - 1'b1; state_d = S_DROP;
        end else state_d = S_DONE;
      end
      S_DROP: begin
        heap_top_d = drop_top;
        state_d = S_DONE;
      end
      S_APP: begin
        if (cnt_q >= CW'(MAX_SEGMENTS)) st_d = ST_FULL;
        else if (ov_q || topx[AddrW]) st_d = ST_OVERFLOW;
        else begin
          heap_top_d = topx[AddrW-1:0];
          cmd.wr = 1'b1; cmd.at = 10'(cnt_q);
          cmd.val = '{start: base[AddrW-1:0], length: need_q, used: 1'b1};
          cnt_d = cnt_q + 1'b1;
          ret_d = base[AddrW-1:0] + AddrW'(HEADER_BYTES);
        end
        state_d = S_DONE;
      end
      S_DONE: if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; heap_start_q <= '0; heap_top_q <= '0;
      cnt_q <= '0; idx_q <= '0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; heap_top_q <= heap_top_d; cnt_q <= cnt_d; idx_q <= idx_d;
      if (cfg_wr) heap_start_q <= pwdata;
      if (state_q == S_DONE && state_d == S_IDLE) out_valid_q <= 1'b1;
      else if (out_acc) out_valid_q <= 1'b0;
    end
  end

  // payload
  logic [AddrW:0] need_x;
  assign need_x = {9'd0, req_len_i} + (AddrW+1)'(HEADER_BYTES);
  always_ff @(posedge clk_i) begin
    ret_q <= ret_d; st_q <= st_d; drop_q <= drop_d;
    if (in_acc) begin
      type_q <= req_type_i; need_q <= need_x[AddrW-1:0]; ov_q <= need_x[AddrW];
      addr_q <= free_addr_i; before_q <= heap_top_q;
    end
    if (state_q == S_DONE && state_d == S_IDLE) begin
      ret_addr_q <= (st_d == ST_OK) ? ret_q : '0;
      top_before_q <= before_q; top_after_q <= heap_top_q; status_q <= st_q;
    end
  end
  assign out_valid_o  = out_valid_q;
  assign ret_addr_o   = ret_addr_q;
  assign top_before_o = top_before_q;
  assign top_after_o  = top_after_q;
  assign status_o     = status_q;
endmodule
`default_nettype wire

/* hdl/ffha_checker.sv */
// Checker: port-level properties of the heap allocator, with its bind.
`default_nettype none
module ffha_checker
  import ffha_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [AddrW-1:0] ret_addr_o,
  input wire logic [StW-1:0]   status_o,
  input wire logic             pready
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ret_addr_o))
    else $error("result dropped under stall");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> ret_addr_o == '0)
    else $error("error result with nonzero address");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i), .ret_addr_o(ret_addr_o), .status_o(status_o),
  .pready(pready)
);
`default_nettype wire
